FILE: rtl/core/svm_pkg.sv
// svm_pkg: shared types and constants for the sample voice mixer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package svm_pkg;
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_WRITE  = 2'd0;
    localparam t_opcode OP_START  = 2'd1;
    localparam t_opcode OP_STOP   = 2'd2;
    localparam t_opcode OP_RENDER = 2'd3;

    localparam int FRAC_BITS = 12;
    localparam int POS_W     = 29;
    localparam logic [16:0] MAX_LEN = 17'd65536;
    localparam logic [15:0] Q15_ONE = 16'h8000;
endpackage
`default_nettype wire

FILE: rtl/core/svm_ram.sv
// svm_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/sample_voice_mixer_top.sv
// sample_voice_mixer_top: stereo sample-playback voice mixer.
// Depends on svm_pkg and svm_ram.
//
//  channel | valid        | stall        | payload
//  input   | i_in_valid   | o_in_stall   | i_opcode .. i_loop_enable
//  output  | o_out_valid  | i_out_stall  | o_left_out, o_right_out, o_active_mask
//
// Each item's result is registered in S_DONE after its acceptance, a render's after
// its walk; the next item is taken once the result has left. Write, start and stop
// have no walk. Render walks VOICE_COUNT slots: an idle slot visits S_VOICE only,
// a slot past its end S_VOICE and S_ADV, a slot on its last frame adds S_RD1 and
// S_GL to S_PR, and interpolation adds S_W0 to S_IR. The sample RAM port and one
// shared multiplier set the per-voice state sequence. The input stalls while an item
// is in work or its result waits. Reset clears all voice state; sample memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sample_voice_mixer_top
    import svm_pkg::*;
#(
    parameter int VOICE_COUNT   = 8,
    parameter int SAMPLE_FRAMES = 65536
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [15:0]        i_address,
    input  wire logic signed [15:0] i_left_sample,
    input  wire logic signed [15:0] i_right_sample,
    input  wire logic [2:0]         i_voice,
    input  wire logic [16:0]        i_length_frames,
    input  wire logic [15:0]        i_pitch_step,
    input  wire logic [15:0]        i_volume,
    input  wire logic signed [15:0] i_pan,
    input  wire logic               i_loop_enable,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_left_out,
    output logic signed [15:0]      o_right_out,
    output logic [7:0]              o_active_mask
);
    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int AW = $clog2(SAMPLE_FRAMES);
    localparam int MW = (VOICE_COUNT < 8) ? VOICE_COUNT : 8;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_VOICE = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_W0    = 4'd3;
    localparam logic [3:0] S_W1    = 4'd4;
    localparam logic [3:0] S_IL    = 4'd5;
    localparam logic [3:0] S_IR    = 4'd6;
    localparam logic [3:0] S_GL    = 4'd7;
    localparam logic [3:0] S_GR    = 4'd8;
    localparam logic [3:0] S_PL    = 4'd9;
    localparam logic [3:0] S_PR    = 4'd10;
    localparam logic [3:0] S_ADV   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] r_state;
    logic [VOICE_COUNT-1:0] r_active;
    logic [15:0]      r_base   [VOICE_COUNT];
    logic [16:0]      r_len    [VOICE_COUNT];
    logic [POS_W-1:0] r_pos    [VOICE_COUNT];
    logic [15:0]      r_step   [VOICE_COUNT];
    logic [15:0]      r_gain   [VOICE_COUNT];
    logic signed [15:0] r_bal  [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] r_rep;

    logic [VW:0]  r_k;
    logic [VW-1:0] k;
    logic signed [15:0] r_l0, r_r0, r_l, r_r;
    logic signed [33:0] r_prod;
    logic signed [32:0] r_tl, r_tr;
    logic signed [39:0] r_accl, r_accr;
    logic signed [15:0] r_out_l, r_out_r;
    logic r_out_valid;

    assign k = r_k[VW-1:0];

    // Current voice fields
    logic [POS_W-1:0] cur_pos;
    logic [16:0] cur_idx;
    logic [FRAC_BITS-1:0] cur_frac;
    logic [16:0] cur_len;
    logic has_cur, has_next;
    assign cur_pos  = r_pos[k];
    assign cur_idx  = cur_pos[POS_W-1:FRAC_BITS];
    assign cur_frac = cur_pos[FRAC_BITS-1:0];
    assign cur_len  = r_len[k];
    assign has_cur  = cur_idx < cur_len;
    assign has_next = ({1'b0, cur_idx} + 18'd1) < {1'b0, cur_len};

    // Pan weights, 17 bits signed positive
    logic signed [17:0] pw_l, pw_r, bal_x;
    assign bal_x = 18'(r_bal[k]);
    assign pw_l = (r_bal[k] < 0) ? 18'sd32768 : 18'sd32768 - bal_x;
    assign pw_r = (r_bal[k] > 0) ? 18'sd32768 : 18'sd32768 + bal_x;

    // Sample RAM
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_rdata;
    logic          accept_in;
    assign accept_in = i_in_valid && !o_in_stall;
    assign ram_we = accept_in && (i_opcode == OP_WRITE);

    always_comb begin
        if (r_state == S_IDLE) begin
            ram_addr = AW'(i_address);
        end else if (r_state == S_VOICE) begin
            ram_addr = AW'(18'(r_base[k]) + 18'(cur_idx));
        end else begin
            ram_addr = AW'(18'(r_base[k]) + 18'(cur_idx) + 18'd1);
        end
    end

    svm_ram #(.WIDTH(32), .DEPTH(SAMPLE_FRAMES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({i_right_sample, i_left_sample}),
        .o_rdata (ram_rdata)
    );

    // Shared multiplier: 18 x 33 signed
    logic signed [17:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [50:0] mul_p;
    logic signed [16:0] f_x, nf_x;
    assign f_x  = 17'($unsigned({1'b0, cur_frac}));
    assign nf_x = 17'sd4096 - f_x;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_W0: begin mul_a = 18'(r_l0); mul_b = 33'(nf_x); end
            S_W1: begin mul_a = 18'($signed(ram_rdata[15:0])); mul_b = 33'(f_x); end
            S_IL: begin mul_a = 18'(r_r0); mul_b = 33'(nf_x); end
            S_IR: begin mul_a = 18'($signed(ram_rdata[31:16])); mul_b = 33'(f_x); end
            S_GL: begin mul_a = pw_l; mul_b = $signed({17'b0, r_gain[k]}); end
            S_GR: begin mul_a = pw_r; mul_b = $signed({17'b0, r_gain[k]}); end
            S_PL: begin mul_a = 18'(r_l); mul_b = r_tl; end
            S_PR: begin mul_a = 18'(r_r); mul_b = r_tr; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Position advance
    logic [POS_W-1:0] adv_pos;
    logic             adv_end;
    assign adv_pos = cur_pos + POS_W'(r_step[k]);
    assign adv_end = adv_pos[POS_W-1:FRAC_BITS] >= cur_len;

    // Saturation
    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -40'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;

    logic [16:0] len_clip;
    logic [15:0] gain_clip;
    assign len_clip  = (i_length_frames > MAX_LEN) ? MAX_LEN : i_length_frames;
    assign gain_clip = (i_volume > Q15_ONE) ? Q15_ONE : i_volume;

    // Main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_rep       <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_base[i] <= '0;
                r_len[i]  <= '0;
                r_pos[i]  <= '0;
                r_step[i] <= '0;
                r_gain[i] <= '0;
                r_bal[i]  <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept_in) begin
                        r_out_l <= '0;
                        r_out_r <= '0;
                        r_accl  <= '0;
                        r_accr  <= '0;
                        r_k     <= '0;
                        r_state <= S_DONE;
                        if (i_opcode == OP_START && 7'(i_voice) < 7'(VOICE_COUNT)) begin
                            r_active[VW'(i_voice)] <= 1'b1;
                            r_base[VW'(i_voice)]   <= i_address;
                            r_len[VW'(i_voice)]    <= len_clip;
                            r_pos[VW'(i_voice)]    <= '0;
                            r_step[VW'(i_voice)]   <= i_pitch_step;
                            r_gain[VW'(i_voice)]   <= gain_clip;
                            r_bal[VW'(i_voice)]    <= i_pan;
                            r_rep[VW'(i_voice)]    <= i_loop_enable;
                        end else if (i_opcode == OP_STOP
                                     && 7'(i_voice) < 7'(VOICE_COUNT)) begin
                            r_active[VW'(i_voice)] <= 1'b0;
                            r_base[VW'(i_voice)]   <= '0;
                            r_len[VW'(i_voice)]    <= '0;
                            r_pos[VW'(i_voice)]    <= '0;
                            r_step[VW'(i_voice)]   <= '0;
                            r_gain[VW'(i_voice)]   <= '0;
                            r_bal[VW'(i_voice)]    <= '0;
                            r_rep[VW'(i_voice)]    <= 1'b0;
                        end else if (i_opcode == OP_RENDER) begin
                            r_state <= S_VOICE;
                        end
                    end
                end
                // Issue read of the current frame, skip idle voice, or go to the advance past the end
                S_VOICE: begin
                    if (!r_active[k]) begin
                        r_state <= S_DONE;
                        if (r_k != (VW+1)'(VOICE_COUNT - 1)) begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_VOICE;
                        end
                    end else if (!has_cur) begin
                        r_state <= S_ADV;
                    end else begin
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_l0 <= $signed(ram_rdata[15:0]);
                    r_r0 <= $signed(ram_rdata[31:16]);
                    r_l  <= $signed(ram_rdata[15:0]);
                    r_r  <= $signed(ram_rdata[31:16]);
                    r_state <= has_next ? S_W0 : S_GL;
                end
                // Interpolate: a*(4096-f) then + b*f, floor by 4096
                S_W0: begin
                    r_prod  <= 34'(mul_p);
                    r_state <= S_W1;
                end
                S_W1: begin
                    r_l     <= 16'((r_prod + 34'(mul_p)) >>> FRAC_BITS);
                    r_state <= S_IL;
                end
                S_IL: begin
                    r_prod  <= 34'(mul_p);
                    r_state <= S_IR;
                end
                S_IR: begin
                    r_r     <= 16'((r_prod + 34'(mul_p)) >>> FRAC_BITS);
                    r_state <= S_GL;
                end
                // Gain times pan weight for each side
                S_GL: begin
                    r_tl    <= 33'(mul_p);
                    r_state <= S_GR;
                end
                S_GR: begin
                    r_tr    <= 33'(mul_p);
                    r_state <= S_PL;
                end
                // Sample times weighted gain, floor by 2^30, accumulate
                S_PL: begin
                    r_accl  <= r_accl + 40'(mul_p >>> 30);
                    r_state <= S_PR;
                end
                S_PR: begin
                    r_accr  <= r_accr + 40'(mul_p >>> 30);
                    r_state <= S_ADV;
                end
                // Advance position, loop or stop, then go to the next voice or finish
                S_ADV: begin
                    if (adv_end) begin
                        r_pos[k] <= r_rep[k] ? '0 : adv_pos;
                        if (!r_rep[k]) begin
                            r_active[k] <= 1'b0;
                        end
                    end else begin
                        r_pos[k] <= adv_pos;
                    end
                    if (r_k != (VW+1)'(VOICE_COUNT - 1)) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_VOICE;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_out_l     <= sat16(r_accl);
                    r_out_r     <= sat16(r_accr);
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Outputs
    logic [7:0] mask_w;
    always_comb begin
        mask_w = '0;
        for (int i = 0; i < MW; i++) begin
            mask_w[i] = r_active[i];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_out    = r_out_l;
    assign o_right_out   = r_out_r;
    assign o_active_mask = mask_w;
endmodule
`default_nettype wire

FILE: tb/sv/sample_voice_mixer_top_tb.sv
// sample_voice_mixer_top_tb: self-checking bench for the stereo voice mixer.
// Depends on svm_pkg and sample_voice_mixer_top; predicts every result in place.
`timescale 1ns / 1ps
module sample_voice_mixer_top_tb;
    import svm_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct {
        t_opcode            op;
        logic [15:0]        addr;
        logic signed [15:0] lsmp;
        logic signed [15:0] rsmp;
        logic [2:0]         vc;
        logic [16:0]        len;
        logic [15:0]        step;
        logic [15:0]        vol;
        logic signed [15:0] pan;
        logic               rep;
    } t_item;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [7:0]         mask;
    } t_mix;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_opcode = '0;
    logic [15:0]        i_address = '0;
    logic signed [15:0] i_left_sample = '0;
    logic signed [15:0] i_right_sample = '0;
    logic [2:0]         i_voice = '0;
    logic [16:0]        i_length_frames = '0;
    logic [15:0]        i_pitch_step = '0;
    logic [15:0]        i_volume = '0;
    logic signed [15:0] i_pan = '0;
    logic               i_loop_enable = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_left_out;
    logic signed [15:0] o_right_out;
    logic [7:0]         o_active_mask;

    sample_voice_mixer_top DUT (.*);

    always #2 i_clk = ~i_clk;

    // Mixer state mirror
    logic [31:0] frame_mem [int];
    logic        vc_on   [8];
    logic [15:0] vc_base [8];
    logic [16:0] vc_len  [8];
    logic [28:0] vc_pos  [8];
    logic [15:0] vc_step [8];
    logic [15:0] vc_gain [8];
    logic signed [15:0] vc_pan [8];
    logic        vc_rep  [8];

    t_mix mix_pending [$];
    int   errors = 0;
    int   quiet_cycles = 0;
    bit   no_idle = 1'b0;
    int   hold_cnt = 0;
    int   sent = 0;

    task automatic report_mismatch(string what, longint want, longint got);
        errors++;
        $display("ERROR %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    endtask

    // Compute the result of one accepted item and advance the mirror
    task automatic mix_predict(t_item it);
        t_mix   res;
        longint accl, accr, l, r, l1, r1, f, pl, pr, g, p;
        int     idx;
        logic [31:0] w0, w1;
        logic [28:0] pos;
        accl = 0;
        accr = 0;
        case (it.op)
            OP_WRITE: frame_mem[it.addr] = {it.rsmp, it.lsmp};
            OP_START: begin
                vc_on[it.vc]   = 1'b1;
                vc_base[it.vc] = it.addr;
                vc_len[it.vc]  = (it.len > MAX_LEN) ? MAX_LEN : it.len;
                vc_pos[it.vc]  = '0;
                vc_step[it.vc] = it.step;
                vc_gain[it.vc] = (it.vol > Q15_ONE) ? Q15_ONE : it.vol;
                vc_pan[it.vc]  = it.pan;
                vc_rep[it.vc]  = it.rep;
            end
            OP_STOP: begin
                vc_on[it.vc] = 1'b0; vc_base[it.vc] = '0; vc_len[it.vc] = '0;
                vc_pos[it.vc] = '0; vc_step[it.vc] = '0; vc_gain[it.vc] = '0;
                vc_pan[it.vc] = '0; vc_rep[it.vc] = 1'b0;
            end
            default: begin
                for (int k = 0; k < 8; k++) begin
                    if (!vc_on[k]) continue;
                    pos = vc_pos[k];
                    idx = pos >> FRAC_BITS;
                    f = pos[11:0];
                    if (idx < vc_len[k]) begin
                        w0 = frame_mem[(vc_base[k] + idx) & 16'hFFFF];
                        l = $signed(w0[15:0]);
                        r = $signed(w0[31:16]);
                        if (idx + 1 < vc_len[k]) begin
                            w1 = frame_mem[(vc_base[k] + idx + 1) & 16'hFFFF];
                            l1 = $signed(w1[15:0]);
                            r1 = $signed(w1[31:16]);
                            l = (l * (4096 - f) + l1 * f) >>> 12;
                            r = (r * (4096 - f) + r1 * f) >>> 12;
                        end
                        p = vc_pan[k];
                        pl = (p < 0) ? 32768 : 32768 - p;
                        pr = (p > 0) ? 32768 : 32768 + p;
                        g = vc_gain[k];
                        accl += (l * g * pl) >>> 30;
                        accr += (r * g * pr) >>> 30;
                    end
                    pos = pos + vc_step[k];
                    if ((pos >> FRAC_BITS) >= vc_len[k]) begin
                        if (vc_rep[k]) pos = '0;
                        else vc_on[k] = 1'b0;
                    end
                    vc_pos[k] = pos;
                end
            end
        endcase
        res.left  = (accl > 32767) ? 16'sd32767 : (accl < -32768) ? -16'sd32768 : accl[15:0];
        res.right = (accr > 32767) ? 16'sd32767 : (accr < -32768) ? -16'sd32768 : accr[15:0];
        for (int k = 0; k < 8; k++) res.mask[k] = vc_on[k];
        mix_pending.push_back(res);
    endtask

    function automatic t_item rand_item(t_opcode op);
        t_item it;
        it.op   = op;
        it.addr = 16'($urandom);
        it.lsmp = 16'($urandom);
        it.rsmp = 16'($urandom);
        it.vc   = 3'($urandom);
        it.len  = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 64));
        it.step = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12000));
        it.vol  = 16'($urandom);
        it.pan  = 16'($urandom);
        it.rep  = 1'($urandom);
        return it;
    endfunction

    // Offer one item; hold it until accepted
    task automatic send_item(t_item it);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 17) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_opcode = it.op; i_address = it.addr; i_left_sample = it.lsmp;
        i_right_sample = it.rsmp; i_voice = it.vc; i_length_frames = it.len;
        i_pitch_step = it.step; i_volume = it.vol; i_pan = it.pan;
        i_loop_enable = it.rep; i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        mix_predict(it);
        sent++;
    endtask

    task automatic write_frame(int a, int l, int r);
        t_item it;
        it = rand_item(OP_WRITE);
        it.addr = 16'(a); it.lsmp = 16'(l); it.rsmp = 16'(r);
        send_item(it);
    endtask

    task automatic start_voice(int v, int base, int len, int step, int vol, int pan, bit rep);
        t_item it;
        it = rand_item(OP_START);
        it.vc = 3'(v); it.addr = 16'(base); it.len = 17'(len); it.step = 16'(step);
        it.vol = 16'(vol); it.pan = 16'(pan); it.rep = rep;
        send_item(it);
    endtask

    // Fill every frame the next render reads, then render
    task automatic render_frame();
        int idx, a;
        t_item it;
        for (int k = 0; k < 8; k++) begin
            if (!vc_on[k]) continue;
            idx = vc_pos[k] >> FRAC_BITS;
            for (int j = 0; j < 2; j++) begin
                if (idx + j < vc_len[k]) begin
                    a = (vc_base[k] + idx + j) & 16'hFFFF;
                    if (!frame_mem.exists(a))
                        write_frame(a, $urandom, $urandom);
                end
            end
        end
        it = rand_item(OP_RENDER);
        send_item(it);
    endtask

    task automatic test_memory_extremes();
        write_frame(0, 32767, -32768);
        write_frame(1, -32768, 32767);
        write_frame(2, 0, 0);
        write_frame(65535, 32767, 32767);
        write_frame(3, -1, 1);
    endtask

    task automatic test_voice_cases();
        start_voice(0, 0, 4, 4096, 32768, -32768, 1);     // full gain, hard left
        start_voice(1, 65535, 3, 2048, 65535, 32767, 0);  // address wrap, oversized volume
        start_voice(2, 0, 0, 4096, 32768, 0, 1);          // zero-length loop
        start_voice(3, 1, 2, 0, 16384, 0, 0);             // zero step
        start_voice(4, 0, 131071, 65535, 0, 100, 0);      // oversized length, max step
        start_voice(5, 2, 1, 4096, 32768, 0, 0);          // ends after one render
        repeat (4) render_frame();
        start_voice(0, 1, 3, 1000, 20000, 5000, 1);       // restart of a busy voice
        start_voice(6, 0, 65536, 65535, 32768, -1, 1);
        start_voice(7, 0, 4, 4095, 32768, 32767, 1);
        repeat (3) render_frame();
        begin
            t_item it;
            it = rand_item(OP_STOP);
            it.vc = 3;
            send_item(it);
        end
        repeat (3) render_frame();
    endtask

    task automatic test_backpressure();
        fork
            hold_cnt = 300;
        join_none
        repeat (6) render_frame();
    endtask

    // Send random items until count more have been accepted
    task automatic test_random(int count, bit quiet);
        int sel;
        int stop_at;
        no_idle = quiet;
        stop_at = sent + count;
        while (sent < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                send_item(rand_item(OP_START));
            end else if (sel < 17) begin
                send_item(rand_item(OP_STOP));
            end else if (sel < 30) begin
                send_item(rand_item(OP_WRITE));
            end else begin
                render_frame();
            end
        end
        no_idle = 1'b0;
    endtask

    // Receiver stall: random, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            i_out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < 17);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_mix want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mix_pending.size() == 0) begin
                errors++;
                $display("ERROR unexpected result at %0t", $realtime);
            end else begin
                want = mix_pending.pop_front();
                if (o_left_out !== want.left)
                    report_mismatch("left_out", want.left, o_left_out);
                if (o_right_out !== want.right)
                    report_mismatch("right_out", want.right, o_right_out);
                if (o_active_mask !== want.mask)
                    report_mismatch("active_mask", want.mask, o_active_mask);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sample_voice_mixer_top: mismatch");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 8; k++) begin
            vc_on[k] = '0; vc_base[k] = '0; vc_len[k] = '0; vc_pos[k] = '0;
            vc_step[k] = '0; vc_gain[k] = '0; vc_pan[k] = '0; vc_rep[k] = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_memory_extremes();
        test_voice_cases();
        test_backpressure();
        test_random(300, 1'b0);
        test_random(150, 1'b1);
        test_random(300, 1'b0);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (mix_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("sample_voice_mixer_top: match");
        end else begin
            $display("sample_voice_mixer_top: mismatch");
        end
        $finish;
    end
endmodule
